[rtl/core/mss_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mss_pkg
// Shared types, codes and reset values for the session sequencer.
// ----------------------------------------------------------------------------
package mss_pkg;

  localparam int MAX_TOPICS_DEFAULT = 16;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_TCP_RETRY_LIMIT  = 3'd0,
    REG_IDLE_TICK_LIMIT  = 3'd1,
    REG_PING_RETRY_LIMIT = 3'd2,
    REG_SUB_RETRY_LIMIT  = 3'd3,
    REG_TOPIC_COUNT      = 3'd4
  } reg_index_t;

  typedef enum logic [2:0] {
    PH_TCP       = 3'd0,
    PH_CONNECT   = 3'd1,
    PH_CONNECTED = 3'd2,
    PH_PING      = 3'd3,
    PH_SUBSCRIBE = 3'd4
  } phase_t;

  typedef enum logic [3:0] {
    ACT_NONE      = 4'd0,
    ACT_TCP       = 4'd1,
    ACT_CONNECT   = 4'd2,
    ACT_HELLO     = 4'd3,
    ACT_SUBSCRIBE = 4'd4,
    ACT_SEND      = 4'd5,
    ACT_PING      = 4'd6,
    ACT_RESTART   = 4'd7,
    ACT_CONSUME   = 4'd8
  } action_t;

  typedef struct packed {
    logic [7:0]  tcp_retry_limit;
    logic [15:0] idle_tick_limit;
    logic [7:0]  ping_retry_limit;
    logic [7:0]  subscribe_retry_limit;
    logic [4:0]  topic_count;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    tcp_retry_limit:       8'd5,
    idle_tick_limit:       16'd10,
    ping_retry_limit:      8'd5,
    subscribe_retry_limit: 8'd5,
    topic_count:           5'd0
  };

  // Input events, last field in the lowest bit.
  typedef struct packed {
    logic tx_send_ok;
    logic tx_not_empty;
    logic publish_ready;
    logic suback_seen;
    logic pong_seen;
    logic connack_seen;
    logic tcp_connect_ok;
    logic timer_due;
  } event_t;

  typedef struct packed {
    phase_t      phase;
    logic        substate_wait;
    logic [7:0]  retry_count;
    logic [15:0] idle_ticks;
    logic        all_subscribed;
    logic        awaiting_suback;
    logic        pong_arrived;
  } sess_t;

  localparam sess_t SESS_RESET = '{
    phase:           PH_TCP,
    substate_wait:   1'b0,
    retry_count:     8'd0,
    idle_ticks:      16'd0,
    all_subscribed:  1'b0,
    awaiting_suback: 1'b0,
    pong_arrived:    1'b0
  };

  typedef struct packed {
    logic        tx_send_failed;
    logic        wait_substate;
    phase_t      session_phase;
    logic [3:0]  topic_index;
    action_t     action;
  } result_t;

endpackage

[rtl/core/mss_cfg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mss_cfg
// Configuration register bank, written through a plain write port.
// ----------------------------------------------------------------------------
module mss_cfg (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [mss_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [mss_pkg::CFG_DATA_W-1:0]  cfg_data,
  output mss_pkg::cfg_t                   cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= mss_pkg::CFG_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        mss_pkg::REG_TCP_RETRY_LIMIT:  cfg.tcp_retry_limit <= cfg_data[7:0];
        mss_pkg::REG_IDLE_TICK_LIMIT:  cfg.idle_tick_limit <= cfg_data[15:0];
        mss_pkg::REG_PING_RETRY_LIMIT: cfg.ping_retry_limit <= cfg_data[7:0];
        mss_pkg::REG_SUB_RETRY_LIMIT:  cfg.subscribe_retry_limit <= cfg_data[7:0];
        mss_pkg::REG_TOPIC_COUNT:      cfg.topic_count <= cfg_data[4:0];
        default: begin
          // drop writes to unmapped indexes
        end
      endcase
    end
  end

endmodule

[rtl/core/mss_step.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mss_step
// Next-state and action logic for one poll tick of the session.
// ----------------------------------------------------------------------------
module mss_step #(
  parameter int MAX_TOPICS = mss_pkg::MAX_TOPICS_DEFAULT,
  localparam int TD_W = $clog2(MAX_TOPICS + 1)
) (
  input  mss_pkg::cfg_t    cfg,
  input  mss_pkg::event_t  ev,
  input  mss_pkg::sess_t   st,
  input  logic [TD_W-1:0]  topics_done,
  output mss_pkg::sess_t   st_next,
  output logic [TD_W-1:0]  topics_done_next,
  output mss_pkg::result_t res
);

  logic [7:0]  retry_inc;
  logic [15:0] idle_cur;
  logic        idle_due;
  logic [31:0] eff_topics;
  logic [31:0] td_wide;
  logic        topics_left;

  assign retry_inc   = (st.retry_count != 8'hFF) ? st.retry_count + 8'd1 : st.retry_count;
  assign idle_cur    = (ev.tx_not_empty && ev.tx_send_ok) ? 16'd0 : st.idle_ticks;
  assign idle_due    = idle_cur >= cfg.idle_tick_limit;
  assign eff_topics  = (32'(cfg.topic_count) > 32'(MAX_TOPICS)) ? 32'(MAX_TOPICS)
                                                               : 32'(cfg.topic_count);
  assign td_wide     = 32'(topics_done);
  assign topics_left = (eff_topics != 32'd0) && (td_wide < eff_topics);

  always_comb begin
    st_next = st;
    topics_done_next = topics_done;
    res.action = mss_pkg::ACT_NONE;
    res.topic_index = 4'd0;
    res.tx_send_failed = 1'b0;

    if (ev.pong_seen) st_next.pong_arrived = 1'b1;
    if (ev.suback_seen) st_next.awaiting_suback = 1'b0;

    if (ev.timer_due) begin
      unique case (st.phase)
        mss_pkg::PH_TCP: begin
          if (!st.substate_wait) begin
            res.action = mss_pkg::ACT_TCP;
            if (ev.tcp_connect_ok) begin
              st_next.phase = mss_pkg::PH_CONNECT;
              st_next.substate_wait = 1'b0;
              st_next.retry_count = 8'd0;
            end else begin
              st_next.retry_count = retry_inc;
              if (retry_inc >= cfg.tcp_retry_limit) begin
                res.action = mss_pkg::ACT_RESTART;
                st_next = mss_pkg::SESS_RESET;
                topics_done_next = '0;
              end
            end
          end
        end
        mss_pkg::PH_CONNECT: begin
          if (!st.substate_wait) begin
            res.action = mss_pkg::ACT_CONNECT;
            st_next.substate_wait = 1'b1;
          end else if (ev.connack_seen) begin
            res.action = mss_pkg::ACT_HELLO;
            st_next.phase = mss_pkg::PH_CONNECTED;
            st_next.substate_wait = 1'b0;
            st_next.retry_count = 8'd0;
          end
        end
        mss_pkg::PH_CONNECTED: begin
          if (!st.substate_wait && !st.all_subscribed) begin
            st_next.phase = mss_pkg::PH_SUBSCRIBE;
            st_next.substate_wait = 1'b0;
            st_next.retry_count = 8'd0;
          end else begin
            st_next.substate_wait = 1'b1;
            if (ev.publish_ready) begin
              res.action = mss_pkg::ACT_CONSUME;
              st_next.idle_ticks = 16'd0;
            end else begin
              if (ev.tx_not_empty) begin
                res.action = mss_pkg::ACT_SEND;
                res.tx_send_failed = !ev.tx_send_ok;
              end
              st_next.idle_ticks = (idle_cur != 16'hFFFF) ? idle_cur + 16'd1 : idle_cur;
              if (idle_due) begin
                st_next.phase = mss_pkg::PH_PING;
                st_next.substate_wait = 1'b0;
                st_next.retry_count = 8'd0;
                st_next.idle_ticks = 16'd0;
              end
            end
          end
        end
        mss_pkg::PH_PING: begin
          if (!st.substate_wait) begin
            res.action = mss_pkg::ACT_PING;
            st_next.pong_arrived = 1'b0;
            st_next.substate_wait = 1'b1;
          end else if (st_next.pong_arrived || retry_inc >= cfg.ping_retry_limit) begin
            st_next.phase = mss_pkg::PH_CONNECTED;
            st_next.substate_wait = 1'b0;
            st_next.retry_count = 8'd0;
          end else begin
            st_next.retry_count = retry_inc;
          end
        end
        mss_pkg::PH_SUBSCRIBE: begin
          if (!st.substate_wait) begin
            if (topics_left) begin
              res.action = mss_pkg::ACT_SUBSCRIBE;
              res.topic_index = td_wide[3:0];
              st_next.awaiting_suback = 1'b1;
              st_next.substate_wait = 1'b1;
            end else begin
              st_next.all_subscribed = 1'b1;
              st_next.phase = mss_pkg::PH_CONNECTED;
              st_next.substate_wait = 1'b0;
              st_next.retry_count = 8'd0;
            end
          end else if (st_next.awaiting_suback) begin
            st_next.retry_count = retry_inc;
            if (retry_inc >= cfg.subscribe_retry_limit) begin
              topics_done_next = TD_W'(td_wide + 32'd1);
              st_next.awaiting_suback = 1'b0;
              st_next.substate_wait = 1'b0;
              st_next.retry_count = 8'd0;
            end
          end else begin
            topics_done_next = TD_W'(td_wide + 32'd1);
            st_next.substate_wait = 1'b0;
            st_next.retry_count = 8'd0;
          end
        end
        default: begin
          st_next = mss_pkg::SESS_RESET;
          topics_done_next = '0;
        end
      endcase
    end

    res.session_phase = st_next.phase;
    res.wait_substate = st_next.substate_wait;
  end

endmodule

[rtl/core/mqtt_session_sequencer_core.sv]
`timescale 1ns / 1ps
// A request is registered at the input, then its result in the output register.
// Throughput: one request per cycle unless the output stalls; the session state
// register updates once per request through a single pass of the step logic.
// Reset: synchronous, active high; clears the session state, loads the
// register defaults and empties both pipeline registers.
// ----------------------------------------------------------------------------
// mqtt_session_sequencer_core
// Publish/subscribe client session sequencer, one poll tick per request.
// ----------------------------------------------------------------------------
module mqtt_session_sequencer_core #(
  parameter int MAX_TOPICS = mss_pkg::MAX_TOPICS_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [mss_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [mss_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // [0] timer_due, [1] tcp_connect_ok, [2] connack_seen, [3] pong_seen,
  // [4] suback_seen, [5] publish_ready, [6] tx_not_empty, [7] tx_send_ok
  input  logic [7:0]                      s_tdata,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // [3:0] action, [7:4] topic_index, [10:8] session_phase,
  // [11] wait_substate, [12] tx_send_failed, [15:13] zero
  output logic [15:0]                     m_tdata
);

  localparam int TD_W = $clog2(MAX_TOPICS + 1);

  mss_pkg::cfg_t    cfg;
  mss_pkg::event_t  in_ev;
  logic             in_valid;
  mss_pkg::sess_t   sess;
  mss_pkg::sess_t   sess_next;
  logic [TD_W-1:0]  topics_done;
  logic [TD_W-1:0]  topics_done_next;
  mss_pkg::result_t res;
  mss_pkg::result_t out_res;
  logic             advance;

  mss_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  mss_step #(
    .MAX_TOPICS (MAX_TOPICS)
  ) u_step (
    .cfg              (cfg),
    .ev               (in_ev),
    .st               (sess),
    .topics_done      (topics_done),
    .st_next          (sess_next),
    .topics_done_next (topics_done_next),
    .res              (res)
  );

  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
    if (s_tready && s_tvalid) begin
      in_ev <= mss_pkg::event_t'(s_tdata);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sess        <= mss_pkg::SESS_RESET;
      topics_done <= '0;
      m_tvalid    <= 1'b0;
    end else if (advance) begin
      sess        <= sess_next;
      topics_done <= topics_done_next;
      m_tvalid    <= 1'b1;
    end else if (m_tready) begin
      m_tvalid    <= 1'b0;
    end
    if (advance) begin
      out_res <= res;
    end
  end

  assign m_tdata = {3'b000, out_res};

  a_advance_fills_output: assert property (@(posedge clk) disable iff (rst)
    advance |=> m_tvalid)
    else $error("output register not filled after advance");

  a_topics_bounded: assert property (@(posedge clk) disable iff (rst)
    32'(topics_done) <= 32'(MAX_TOPICS))
    else $error("topic progress beyond topic limit");

  a_restart_clears: assert property (@(posedge clk) disable iff (rst)
    advance && res.action == mss_pkg::ACT_RESTART |=>
      sess.phase == mss_pkg::PH_TCP && sess.retry_count == 8'd0 && topics_done == '0)
    else $error("restart did not clear the session");

  a_tcp_send_only: assert property (@(posedge clk) disable iff (rst)
    sess.phase == mss_pkg::PH_TCP |-> !sess.substate_wait)
    else $error("wait substate in tcp connect phase");

  a_stall_holds_state: assert property (@(posedge clk) disable iff (rst)
    !advance |=> $stable(sess) && $stable(topics_done))
    else $error("session state changed without a request");

endmodule
